/* hw/rtl/lmrs_pkg.sv */
// lmrs_pkg: shared constants, request/mode codes and the controller/datapath
// command and status structs of the LED matrix row scanner.
// No dependencies.
package lmrs_pkg;

  localparam int ROW_COUNT   = 10;
  localparam int COL_COUNT   = 6;
  localparam int ROW_W       = 4;
  localparam int COL_W       = 3;
  localparam int ROW_FIELD_W = 10;                 // row select bits, 0x03FF
  localparam int WORD_W      = 16;
  localparam int BIT_W       = 4;
  localparam int VALUE_W     = 8;
  localparam int DWELL_W     = 16;
  localparam int PADDR_W     = 2;
  localparam int PDATA_W     = 32;

  localparam logic [BIT_W-1:0]   TOP_BIT      = BIT_W'(WORD_W - 1);
  localparam logic [VALUE_W-1:0] ON_THRESHOLD = 8'h30;   // ASCII '0'
  localparam logic [DWELL_W-1:0] DWELL_RESET  = 16'd500;
  localparam logic [PADDR_W-1:0] REG_DWELL_ADDR = 2'd0;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_LOAD    = 3'd1,
    MODE_SHIFT   = 3'd2,
    MODE_PULSE   = 3'd3,
    MODE_ENABLE  = 3'd4,
    MODE_DISPLAY = 3'd5
  } scan_mode_e;

  typedef struct packed {
    logic             out_load;
    logic             write_px;
    logic             row_clr;
    logic             row_inc;
    logic             load_word;
    logic             set_data;
    logic [BIT_W-1:0] bit_idx;
    logic             clk_lo;
    logic             clk_hi;
    logic             blank_hi;
    logic             blank_lo;
    logic             dwell_clr;
    logic             dwell_inc;
    logic             idle_next;
  } cmd_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] req;
    logic       dwell_done;
    logic       last_row;
  } stat_t;

endpackage

/* hw/rtl/lmrs_in_if.sv */
// lmrs_in_if: request channel (valid/ready plus request payload).
// Depends on lmrs_pkg.
interface lmrs_in_if;
  import lmrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [ROW_W-1:0]   pixel_row;
  logic [COL_W-1:0]   pixel_col;
  logic [VALUE_W-1:0] pixel_value;

  modport source (output valid, req_type, pixel_row, pixel_col, pixel_value,
                  input ready);
  modport sink (input valid, req_type, pixel_row, pixel_col, pixel_value,
                output ready);
endinterface

/* hw/rtl/lmrs_out_if.sv */
// lmrs_out_if: result channel (valid/ready plus pin levels and scan status).
// Depends on lmrs_pkg.
interface lmrs_out_if;
  import lmrs_pkg::*;

  logic             valid;
  logic             ready;
  logic             serial_data;
  logic             serial_clock;
  logic             output_blank;
  logic             ready_res;
  logic [ROW_W-1:0] active_row;

  modport source (output valid, serial_data, serial_clock, output_blank,
                  ready_res, active_row, input ready);
  modport sink (input valid, serial_data, serial_clock, output_blank,
                ready_res, active_row, output ready);
endinterface

/* hw/rtl/lmrs_ctrl.sv */
// lmrs_ctrl: scan state machine, shift bit counter and clock phase.
// Depends on lmrs_pkg; drives the datapath through cmd_t, reads stat_t.
module lmrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lmrs_pkg::stat_t stat_i,
  output lmrs_pkg::cmd_t  cmd_o
);
  import lmrs_pkg::*;

  scan_mode_e       state_q, state_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic             phase_q, phase_d;
  req_e             req;

  assign req = req_e'(stat_i.req);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MODE_IDLE;
      bit_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      phase_q <= phase_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (stat_i.accept) begin
      unique case (req)
        REQ_START: state_d = MODE_LOAD;
        REQ_TICK: begin
          unique case (state_q)
            MODE_LOAD:   state_d = MODE_SHIFT;
            MODE_SHIFT: begin
              if (phase_q && (bit_q == '0)) state_d = MODE_PULSE;
            end
            MODE_PULSE: begin
              if (phase_q) state_d = MODE_ENABLE;
            end
            MODE_ENABLE: state_d = MODE_DISPLAY;
            MODE_DISPLAY: begin
              if (stat_i.dwell_done) begin
                state_d = stat_i.last_row ? MODE_IDLE : MODE_LOAD;
              end
            end
            MODE_IDLE:   state_d = MODE_IDLE;
            default:     state_d = MODE_IDLE;
          endcase
        end
        default: state_d = state_q;   // pixel write or unused code
      endcase
    end
  end

  // commands, bit counter, clock phase
  always_comb begin
    cmd_o          = '0;
    cmd_o.bit_idx  = bit_q;
    bit_d          = bit_q;
    phase_d        = phase_q;
    if (stat_i.accept) begin
      cmd_o.out_load = 1'b1;
      unique case (req)
        REQ_WRITE: cmd_o.write_px = 1'b1;
        REQ_START: begin
          cmd_o.row_clr   = 1'b1;
          cmd_o.dwell_clr = 1'b1;
          bit_d           = '0;
          phase_d         = 1'b0;
        end
        REQ_TICK: begin
          unique case (state_q)
            MODE_LOAD: begin
              cmd_o.load_word = 1'b1;
              cmd_o.blank_hi  = 1'b1;
              bit_d           = TOP_BIT;
              phase_d         = 1'b0;
            end
            MODE_SHIFT: begin
              if (!phase_q) begin
                cmd_o.clk_lo   = 1'b1;
                cmd_o.set_data = 1'b1;
                phase_d        = 1'b1;
              end else begin
                cmd_o.clk_hi = 1'b1;
                phase_d      = 1'b0;
                if (bit_q != '0) bit_d = bit_q - 1'b1;
              end
            end
            MODE_PULSE: begin
              if (!phase_q) begin
                cmd_o.clk_lo = 1'b1;
                phase_d      = 1'b1;
              end else begin
                cmd_o.clk_hi = 1'b1;
                phase_d      = 1'b0;
              end
            end
            MODE_ENABLE: begin
              cmd_o.blank_lo  = 1'b1;
              cmd_o.dwell_clr = 1'b1;
            end
            MODE_DISPLAY: begin
              if (stat_i.dwell_done) begin
                cmd_o.dwell_clr = 1'b1;
                cmd_o.row_inc   = !stat_i.last_row;
              end else begin
                cmd_o.dwell_inc = 1'b1;
              end
            end
            default: ;   // idle: tick changes nothing
          endcase
        end
        default: ;       // unused code: report current levels
      endcase
    end
    cmd_o.idle_next = (state_d == MODE_IDLE);
  end

endmodule

/* hw/rtl/lmrs_dp.sv */
// lmrs_dp: frame store, shift word, row and dwell counters, pin levels,
// dwell register with its APB port, and the result register.
// Depends on lmrs_pkg, lmrs_in_if, lmrs_out_if.
module lmrs_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lmrs_in_if.sink                   in_if,
  lmrs_out_if.source                out_if,
  input  lmrs_pkg::cmd_t            cmd_i,
  output lmrs_pkg::stat_t           stat_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lmrs_pkg::PADDR_W-1:0] paddr,
  input  logic [lmrs_pkg::PDATA_W-1:0] pwdata,
  output logic [lmrs_pkg::PDATA_W-1:0] prdata,
  output logic                      pready
);
  import lmrs_pkg::*;

  logic [COL_COUNT-1:0] frame_q [ROW_COUNT];   // column c at bit COL_COUNT-1-c
  logic [WORD_W-1:0]    word_q, word_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [DWELL_W-1:0]   dwell_q, dwell_d;
  logic [DWELL_W-1:0]   dwell_ticks_q;
  logic                 data_q, data_d;
  logic                 clk_q, clk_d;
  logic                 blank_q, blank_d;
  logic                 out_valid_q;
  logic                 accept;
  logic                 px_ok;
  logic                 px_on;
  logic [COL_W-1:0]     col_bit;

  // handshake: take a request whenever the result register is free or drains
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign stat_o.accept     = accept;
  assign stat_o.req        = in_if.req_type;
  assign stat_o.dwell_done = (dwell_q >= dwell_ticks_q);
  assign stat_o.last_row   = (row_q == ROW_W'(ROW_COUNT - 1));

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DWELL_ADDR) ? PDATA_W'(dwell_ticks_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ticks_q <= DWELL_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_DWELL_ADDR)) begin
      dwell_ticks_q <= pwdata[DWELL_W-1:0];
    end
  end

  // pixel write
  assign px_ok   = (in_if.pixel_row < ROW_W'(ROW_COUNT)) &&
                   (in_if.pixel_col < COL_W'(COL_COUNT));
  assign px_on   = (in_if.pixel_value > ON_THRESHOLD);
  assign col_bit = COL_W'(COL_COUNT - 1) - in_if.pixel_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) frame_q[r] <= '0;
    end else if (cmd_i.write_px && px_ok) begin
      frame_q[in_if.pixel_row][col_bit] <= px_on;
    end
  end

  // shift word: columns above the active-low row select
  always_comb begin
    word_d = word_q;
    if (cmd_i.load_word) begin
      word_d = '0;
      word_d[ROW_FIELD_W +: COL_COUNT] = frame_q[row_q];
      for (int i = 0; i < ROW_FIELD_W; i++) begin
        word_d[i] = (row_q != ROW_W'(i));
      end
    end
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.row_clr)      row_d = '0;
    else if (cmd_i.row_inc) row_d = row_q + 1'b1;
  end

  always_comb begin
    dwell_d = dwell_q;
    if (cmd_i.dwell_clr)      dwell_d = '0;
    else if (cmd_i.dwell_inc) dwell_d = dwell_q + 1'b1;
  end

  always_comb begin
    data_d  = cmd_i.set_data ? word_q[cmd_i.bit_idx] : data_q;
    clk_d   = clk_q;
    if (cmd_i.clk_lo)      clk_d = 1'b0;
    else if (cmd_i.clk_hi) clk_d = 1'b1;
    blank_d = blank_q;
    if (cmd_i.blank_hi)      blank_d = 1'b1;
    else if (cmd_i.blank_lo) blank_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      row_q   <= '0;
      dwell_q <= '0;
      data_q  <= 1'b0;
      clk_q   <= 1'b0;
      blank_q <= 1'b1;
    end else begin
      word_q  <= word_d;
      row_q   <= row_d;
      dwell_q <= dwell_d;
      data_q  <= data_d;
      clk_q   <= clk_d;
      blank_q <= blank_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_if.serial_data  <= data_d;
      out_if.serial_clock <= clk_d;
      out_if.output_blank <= blank_d;
      out_if.ready_res    <= cmd_i.idle_next;
      out_if.active_row   <= row_d;
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

/* hw/rtl/led_matrix_row_scanner.sv */
// led_matrix_row_scanner: top level of the 10x6 LED matrix row scanner.
// Depends on lmrs_pkg, lmrs_in_if, lmrs_out_if, lmrs_ctrl, lmrs_dp.
//
//  channel   dir  kind        payload
//  in_if     in   valid/rdy   req_type, pixel_row, pixel_col, pixel_value
//  out_if    out  valid/rdy   serial_data, serial_clock, output_blank,
//                             ready_res, active_row
//  apb       in   APB rd/wr   dwell_ticks at byte address 0
//
// One request per clock unless out_if stalls: every request is a single
// state update and its result is captured in the result register in the
// same cycle. The result register sets the rate; a request is taken
// whenever it is empty or being drained in the same cycle. Reset (rst_ni,
// async, low) clears the frame, puts the scanner idle with blank high and
// loads dwell_ticks with 500. A stalled out_if holds in_if off.
module led_matrix_row_scanner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lmrs_in_if.sink                      in_if,
  lmrs_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lmrs_pkg::PADDR_W-1:0] paddr,
  input  logic [lmrs_pkg::PDATA_W-1:0] pwdata,
  output logic [lmrs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import lmrs_pkg::*;

  cmd_t  cmd;    // controller -> datapath
  stat_t stat;   // datapath -> controller

  // scan sequencing: load, 16 two-tick bit transfers, extra pulse,
  // enable, then dwell before the next row
  lmrs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // storage, counters, pin levels, config register and result register
  lmrs_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

endmodule
